@@ rtl/core/chacha20_stream_cipher_core_defines.svh @@
// Assertion macros used by the checker file
`ifndef CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH
`define CHACHA20_STREAM_CIPHER_CORE_DEFINES_SVH

// same-cycle implication
`define CSC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication
`define CSC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

@@ rtl/core/cc20_pkg.sv @@
package cc20_pkg;

   localparam int ROUNDS_DEFAULT = 20;

   localparam logic [31:0] SIGMA0 = 32'h61707865;
   localparam logic [31:0] SIGMA1 = 32'h3320646e;
   localparam logic [31:0] SIGMA2 = 32'h79622d32;
   localparam logic [31:0] SIGMA3 = 32'h6b206574;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY01      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY23      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY45      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY67      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NONCE_HIGH = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CTR_START  = 3'd6;

   localparam logic [4:0] POS_EMPTY = 5'd16;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic round_en;
      logic diag;
      logic add_en;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic need_block;
      logic out_busy;
   } status_type;

   function automatic logic [31:0] rotl(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [127:0] quarter(logic [31:0] a, logic [31:0] b,
                                            logic [31:0] c, logic [31:0] d);
      logic [31:0] ta;
      logic [31:0] tb;
      logic [31:0] tc;
      logic [31:0] td;
      ta = a + b;
      td = rotl(d ^ ta, 16);
      tc = c + td;
      tb = rotl(b ^ tc, 12);
      ta = ta + tb;
      td = rotl(td ^ ta, 8);
      tc = tc + td;
      tb = rotl(tb ^ tc, 7);
      return {ta, tb, tc, td};
   endfunction

endpackage

@@ rtl/core/cc20_controller.sv @@
module cc20_controller #(
   parameter int ROUNDS = cc20_pkg::ROUNDS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cc20_pkg::status_type status,
   output cc20_pkg::cmd_type    cmd
);

   localparam int RCW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

   cc20_pkg::state_type state_ff;
   cc20_pkg::state_type state_in;
   logic [RCW-1:0]      cnt_ff;
   logic [RCW-1:0]      cnt_in;
   logic                last_round;

   assign last_round = (cnt_ff == RCW'(ROUNDS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cc20_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         cc20_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = status.need_block ? cc20_pkg::ST_ROUND : cc20_pkg::ST_EMIT;
            end
         end
         cc20_pkg::ST_ROUND: begin
            cnt_in = cnt_ff + 1'b1;
            if (last_round) begin
               state_in = cc20_pkg::ST_ADD;
            end
         end
         cc20_pkg::ST_ADD: begin
            state_in = cc20_pkg::ST_EMIT;
         end
         cc20_pkg::ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = cc20_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cc20_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         cc20_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         cc20_pkg::ST_ROUND: begin
            cmd.round_en = 1'b1;
            cmd.diag     = cnt_ff[0];
         end
         cc20_pkg::ST_ADD: begin
            cmd.add_en = 1'b1;
         end
         cc20_pkg::ST_EMIT: begin
            cmd.emit = !status.out_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/core/cc20_datapath.sv @@
module cc20_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [cc20_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [63:0]                       csr_data,
   input  logic [31:0]                       req_data_in,
   input  logic [2:0]                        req_byte_count,
   input  logic                              req_keystream_only,
   input  logic                              req_restart,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_data_out,
   output logic [2:0]                        rsp_out_byte_count,
   output logic                              rsp_out_last,
   input  cc20_pkg::cmd_type                 cmd,
   output cc20_pkg::status_type              status
);

   logic [63:0] key01_ff;
   logic [63:0] key23_ff;
   logic [63:0] key45_ff;
   logic [63:0] key67_ff;
   logic [63:0] nonce_low_ff;
   logic [31:0] nonce_high_ff;
   logic [31:0] ctr_start_ff;
   logic [31:0] ctr_ff;
   logic [4:0]  pos_ff;

   logic [31:0] data_ff;
   logic [2:0]  count_ff;
   logic        ks_only_ff;
   logic        last_ff;

   logic [31:0] work_ff [16];
   logic [31:0] work_in [16];
   logic [31:0] ks_ff [16];
   logic [31:0] init_w [16];
   logic [31:0] load_w [16];
   logic [31:0] load_ctr;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic [2:0]  rsp_count_ff;
   logic        rsp_last_ff;

   logic [2:0]  count_sat;
   logic [31:0] mask;
   logic [31:0] ks_word;
   logic [31:0] res_word;

   assign status.need_block = req_restart || (pos_ff >= cc20_pkg::POS_EMPTY);
   assign status.out_busy   = rsp_valid_ff && rsp_stall;

   assign load_ctr = req_restart ? ctr_start_ff : ctr_ff;

   always_comb begin
      init_w[0]  = cc20_pkg::SIGMA0;
      init_w[1]  = cc20_pkg::SIGMA1;
      init_w[2]  = cc20_pkg::SIGMA2;
      init_w[3]  = cc20_pkg::SIGMA3;
      init_w[4]  = key01_ff[31:0];
      init_w[5]  = key01_ff[63:32];
      init_w[6]  = key23_ff[31:0];
      init_w[7]  = key23_ff[63:32];
      init_w[8]  = key45_ff[31:0];
      init_w[9]  = key45_ff[63:32];
      init_w[10] = key67_ff[31:0];
      init_w[11] = key67_ff[63:32];
      init_w[12] = ctr_ff;
      init_w[13] = nonce_low_ff[31:0];
      init_w[14] = nonce_low_ff[63:32];
      init_w[15] = nonce_high_ff;
      for (int i = 0; i < 16; i++) begin
         load_w[i] = init_w[i];
      end
      load_w[12] = load_ctr;
   end

   always_comb begin
      logic [127:0] qr;
      for (int q = 0; q < 4; q++) begin
         work_in[q]      = work_ff[q];
         work_in[4 + q]  = work_ff[4 + q];
         work_in[8 + q]  = work_ff[8 + q];
         work_in[12 + q] = work_ff[12 + q];
      end
      for (int q = 0; q < 4; q++) begin
         if (cmd.diag) begin
            qr = cc20_pkg::quarter(work_ff[q], work_ff[4 + ((q + 1) % 4)],
                                   work_ff[8 + ((q + 2) % 4)], work_ff[12 + ((q + 3) % 4)]);
            work_in[q]                  = qr[127:96];
            work_in[4 + ((q + 1) % 4)]  = qr[95:64];
            work_in[8 + ((q + 2) % 4)]  = qr[63:32];
            work_in[12 + ((q + 3) % 4)] = qr[31:0];
         end else begin
            qr = cc20_pkg::quarter(work_ff[q], work_ff[4 + q], work_ff[8 + q], work_ff[12 + q]);
            work_in[q]      = qr[127:96];
            work_in[4 + q]  = qr[95:64];
            work_in[8 + q]  = qr[63:32];
            work_in[12 + q] = qr[31:0];
         end
      end
   end

   always_comb begin
      case (req_byte_count)
         3'd0:    count_sat = 3'd1;
         3'd1:    count_sat = 3'd1;
         3'd2:    count_sat = 3'd2;
         3'd3:    count_sat = 3'd3;
         default: count_sat = 3'd4;
      endcase
   end

   always_comb begin
      case (count_ff)
         3'd1:    mask = 32'h0000_00ff;
         3'd2:    mask = 32'h0000_ffff;
         3'd3:    mask = 32'h00ff_ffff;
         default: mask = 32'hffff_ffff;
      endcase
   end

   assign ks_word  = ks_ff[pos_ff[3:0]];
   assign res_word = (ks_only_ff ? ks_word : (data_ff ^ ks_word)) & mask;

   always_ff @(posedge clock) begin
      if (reset) begin
         key01_ff      <= '0;
         key23_ff      <= '0;
         key45_ff      <= '0;
         key67_ff      <= '0;
         nonce_low_ff  <= '0;
         nonce_high_ff <= '0;
         ctr_start_ff  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            cc20_pkg::CSR_KEY01:      key01_ff      <= csr_data;
            cc20_pkg::CSR_KEY23:      key23_ff      <= csr_data;
            cc20_pkg::CSR_KEY45:      key45_ff      <= csr_data;
            cc20_pkg::CSR_KEY67:      key67_ff      <= csr_data;
            cc20_pkg::CSR_NONCE_LOW:  nonce_low_ff  <= csr_data;
            cc20_pkg::CSR_NONCE_HIGH: nonce_high_ff <= csr_data[31:0];
            cc20_pkg::CSR_CTR_START:  ctr_start_ff  <= csr_data[31:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
         pos_ff <= cc20_pkg::POS_EMPTY;
      end else if (cmd.accept && req_restart) begin
         ctr_ff <= ctr_start_ff;
         pos_ff <= cc20_pkg::POS_EMPTY;
      end else if (cmd.add_en) begin
         ctr_ff <= ctr_ff + 32'd1;
         pos_ff <= '0;
      end else if (cmd.emit) begin
         pos_ff <= last_ff ? cc20_pkg::POS_EMPTY : pos_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         data_ff    <= req_data_in;
         count_ff   <= count_sat;
         ks_only_ff <= req_keystream_only;
         last_ff    <= req_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int i = 0; i < 16; i++) begin
            work_ff[i] <= load_w[i];
         end
      end else if (cmd.round_en) begin
         for (int i = 0; i < 16; i++) begin
            work_ff[i] <= work_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_en) begin
         for (int i = 0; i < 16; i++) begin
            ks_ff[i] <= work_ff[i] + init_w[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff  <= res_word;
         rsp_count_ff <= count_ff;
         rsp_last_ff  <= last_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data_out       = rsp_data_ff;
   assign rsp_out_byte_count = rsp_count_ff;
   assign rsp_out_last       = rsp_last_ff;

endmodule

@@ rtl/core/chacha20_stream_cipher_core.sv @@
// ChaCha20 stream cipher core, one 32-bit message word per request.
// Request channel (req_*): data word, byte count 1..4, keystream-only, restart
// and last flags; taken when req_valid is high and req_stall is low.
// Response channel (rsp_*): one word per request, unused bytes zeroed,
// out_last copied from the request; the core holds it while rsp_stall is high.
// Register channel (csr_*): key, nonce and start counter, index as listed;
// csr_ready is always high. Write it only while the core is idle.
// A request that reuses the current keystream block goes from acceptance
// straight to the emit state, and rsp_valid is registered from there; one
// that needs a new block (first word, word seventeen, after last or on
// restart) first passes through the round state, the single round unit doing
// one round per cycle, and the add state before the emit state.
// One request is in flight at a time: the next is taken only once the
// controller has left the emit state and is idle again.
// A stalled response blocks the next request from completing but not from
// being accepted.
// Reset (synchronous, active high) clears the registers to zero, the block
// counter to zero and marks the keystream block as used up.
module chacha20_stream_cipher_core #(
   parameter int ROUNDS = cc20_pkg::ROUNDS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [cc20_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]                    csr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [31:0]                    req_data_in,
   input  logic [2:0]                     req_byte_count,
   input  logic                           req_keystream_only,
   input  logic                           req_restart,
   input  logic                           req_last,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [31:0]                    rsp_data_out,
   output logic [2:0]                     rsp_out_byte_count,
   output logic                           rsp_out_last
);

   cc20_pkg::cmd_type    cmd;
   cc20_pkg::status_type status;

   assign csr_ready = 1'b1;

   cc20_controller #(
      .ROUNDS(ROUNDS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cc20_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_data_in        (req_data_in),
      .req_byte_count     (req_byte_count),
      .req_keystream_only (req_keystream_only),
      .req_restart        (req_restart),
      .req_last           (req_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_data_out       (rsp_data_out),
      .rsp_out_byte_count (rsp_out_byte_count),
      .rsp_out_last       (rsp_out_last),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

@@ rtl/core/cc20_checker.sv @@
`include "chacha20_stream_cipher_core_defines.svh"

module cc20_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_data_out,
   input logic [2:0]  rsp_out_byte_count
);

   `CSC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data_out))
   `CSC_ASSERT_IMP(a_count_range, clock, reset, rsp_valid, rsp_out_byte_count != 3'd0 && rsp_out_byte_count <= 3'd4)
   `CSC_ASSERT_IMP(a_one_byte_zeroed, clock, reset, rsp_valid && rsp_out_byte_count == 3'd1, rsp_data_out[31:8] == 24'd0)
   `CSC_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall)
   `CSC_ASSERT_NXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)

endmodule

bind chacha20_stream_cipher_core cc20_checker u_cc20_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_data_out       (rsp_data_out),
   .rsp_out_byte_count (rsp_out_byte_count)
);
